[rtl/kf200_pkg.sv]
// ----------------------------------------------------------------------------
// kf200_pkg
// Shared types, constants and the Keccak-f[200] round function used by the
// sponge absorber: lane tables, round constants and the queue item format.
// ----------------------------------------------------------------------------
package kf200_pkg;

  localparam int LANE_COUNT      = 25;
  localparam int INPUT_LANES     = 9;
  localparam int TOTAL_ROUNDS    = 18;
  localparam int DEF_ROUNDS      = 18;
  localparam int DEF_RATE_LANES  = 9;
  // rounds evaluated by the permutation unit in one clock
  localparam int ROUNDS_PER_STEP = 3;
  // round counter width, covers TOTAL_ROUNDS plus one step of overshoot
  localparam int RND_W           = 5;
  localparam int CHUNK_W         = 64;
  localparam int CHUNK_LANES     = 8;
  localparam int CHUNK_IDX_W     = 2;
  localparam logic [CHUNK_IDX_W-1:0] LAST_CHUNK_IDX = 2'd3;

  // input queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [LANE_COUNT-1:0][7:0] lanes_t;

  // one rate block as it travels from the front end to the permutation unit
  typedef struct packed {
    logic [INPUT_LANES-1:0][7:0] lanes;
    logic                        final_block;
  } blk_t;

  // state snapshot handed to the chunk serializer
  typedef struct packed {
    logic   load;
    lanes_t lanes;
  } snap_t;

  // rho offsets (mod 8), indexed by x+5y
  localparam logic [2:0] ROT_AMT [LANE_COUNT] = '{
    3'd0, 3'd1, 3'd6, 3'd4, 3'd3,
    3'd4, 3'd4, 3'd6, 3'd7, 3'd4,
    3'd3, 3'd2, 3'd3, 3'd1, 3'd7,
    3'd1, 3'd5, 3'd7, 3'd5, 3'd0,
    3'd2, 3'd2, 3'd5, 3'd0, 3'd6
  };

  // pi destination of source lane x+5y: y + 5*((2x+3y) mod 5)
  localparam logic [4:0] PI_DEST [LANE_COUNT] = '{
    5'd0,  5'd10, 5'd20, 5'd5,  5'd15,
    5'd16, 5'd1,  5'd11, 5'd21, 5'd6,
    5'd7,  5'd17, 5'd2,  5'd12, 5'd22,
    5'd23, 5'd8,  5'd18, 5'd3,  5'd13,
    5'd14, 5'd24, 5'd9,  5'd19, 5'd4
  };

  // iota constants, low byte of the 64-bit Keccak constants
  localparam logic [7:0] ROUND_CONST [TOTAL_ROUNDS] = '{
    8'h01, 8'h82, 8'h8A, 8'h00, 8'h8B, 8'h01, 8'h81, 8'h09, 8'h8A,
    8'h88, 8'h09, 8'h0A, 8'h8B, 8'h8B, 8'h89, 8'h03, 8'h02, 8'h80
  };

  function automatic logic [7:0] rotl8(logic [7:0] v, logic [2:0] r);
    logic [15:0] t;
    t = {v, v} << r;
    return t[15:8];
  endfunction

  function automatic logic [7:0] round_const(logic [RND_W-1:0] i);
    logic [7:0] rc;
    rc = '0;
    if (i < RND_W'(TOTAL_ROUNDS)) begin
      rc = ROUND_CONST[i];
    end
    return rc;
  endfunction

  // one round: theta, rho, pi, chi, iota
  function automatic lanes_t keccak_round(lanes_t a, logic [7:0] rc);
    logic [4:0][7:0] c;
    logic [4:0][7:0] d;
    lanes_t t;
    lanes_t b;
    lanes_t s;
    int xm;
    int xp;
    int x2;
    c = '0;
    // column parities
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        c[x] = c[x] ^ a[x + 5 * y];
      end
    end
    // theta
    for (int x = 0; x < 5; x++) begin
      xm = (x == 0) ? 4 : x - 1;
      xp = (x == 4) ? 0 : x + 1;
      d[x] = c[xm] ^ rotl8(c[xp], 3'd1);
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        t[x + 5 * y] = a[x + 5 * y] ^ d[x];
      end
    end
    // rho and pi
    b = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      b[PI_DEST[i]] = rotl8(t[i], ROT_AMT[i]);
    end
    // chi
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        xp = (x == 4) ? 0 : x + 1;
        x2 = (x >= 3) ? x - 3 : x + 2;
        s[x + 5 * y] = b[x + 5 * y] ^ (~b[xp + 5 * y] & b[x2 + 5 * y]);
      end
    end
    // iota
    s[0] = s[0] ^ rc;
    return s;
  endfunction

endpackage

[rtl/kf200_front.sv]
// ----------------------------------------------------------------------------
// kf200_front
// Input front end: takes rate blocks off the input channel, tags them with
// their final flag and holds them in a two-entry queue for the permutation.
// ----------------------------------------------------------------------------
module kf200_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kf200_pkg::blk_t   in_item,
  output logic              q_valid,
  output kf200_pkg::blk_t   q_item,
  input  logic              q_pop
);
  import kf200_pkg::*;

  blk_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               push;

  assign in_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/kf200_perm.sv]
// ----------------------------------------------------------------------------
// kf200_perm
// Permutation unit: holds the 25-lane state, absorbs a block into the rate
// lanes and runs the rounds a few per clock, then hands final states on.
// ----------------------------------------------------------------------------
module kf200_perm #(
  parameter int ROUNDS     = kf200_pkg::DEF_ROUNDS,
  parameter int RATE_LANES = kf200_pkg::DEF_RATE_LANES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  kf200_pkg::blk_t   q_item,
  output logic              q_pop,
  input  logic              out_free,
  output kf200_pkg::snap_t  snap
);
  import kf200_pkg::*;

  localparam logic [RND_W-1:0] ROUNDS_V = RND_W'(ROUNDS);
  localparam logic [RND_W-1:0] RC_BASE  = RND_W'(TOTAL_ROUNDS - ROUNDS);
  localparam logic [RND_W-1:0] STEP_V   = RND_W'(ROUNDS_PER_STEP);

  lanes_t           state;
  lanes_t           state_next;
  lanes_t           work_in;
  lanes_t           stage [ROUNDS_PER_STEP+1];
  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] base;
  logic [RND_W-1:0] rnd_j [ROUNDS_PER_STEP];
  logic             busy;
  logic             final_r;
  logic             cur_final;
  logic             last_step;
  logic             fire;
  logic             stall;
  logic             advance;

  // step control
  assign base      = busy ? rnd : '0;
  assign cur_final = busy ? final_r : q_item.final_block;
  assign last_step = (base + STEP_V) >= ROUNDS_V;
  assign fire      = busy || q_valid;
  assign stall     = last_step && cur_final && !out_free;
  assign advance   = fire && !stall;
  assign q_pop     = !busy && q_valid && !stall;

  // absorb on the first step, then a chain of rounds
  always_comb begin
    work_in = state;
    if (!busy) begin
      for (int i = 0; i < INPUT_LANES; i++) begin
        if (i < RATE_LANES) begin
          work_in[i] = state[i] ^ q_item.lanes[i];
        end
      end
    end
    stage[0] = work_in;
    for (int j = 0; j < ROUNDS_PER_STEP; j++) begin
      rnd_j[j] = base + RND_W'(j);
      if (rnd_j[j] < ROUNDS_V) begin
        stage[j+1] = keccak_round(stage[j], round_const(RC_BASE + rnd_j[j]));
      end else begin
        stage[j+1] = stage[j];
      end
    end
    state_next = stage[ROUNDS_PER_STEP];
  end

  // hand finished final states to the serializer
  assign snap.load  = advance && last_step && cur_final;
  assign snap.lanes = state_next;

  // state and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= '0;
      busy    <= 1'b0;
      rnd     <= '0;
      final_r <= 1'b0;
    end else if (advance) begin
      state <= state_next;
      if (last_step) begin
        busy <= 1'b0;
        rnd  <= '0;
      end else begin
        busy    <= 1'b1;
        rnd     <= base + STEP_V;
        final_r <= cur_final;
      end
    end
  end

endmodule

[rtl/kf200_out.sv]
// ----------------------------------------------------------------------------
// kf200_out
// Chunk serializer: keeps a snapshot of a final state and offers it as four
// 64-bit chunks, one transfer each, lane index ascending from the low byte.
// ----------------------------------------------------------------------------
module kf200_out (
  input  logic                              clk,
  input  logic                              rst,
  input  kf200_pkg::snap_t                  snap,
  output logic                              out_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kf200_pkg::CHUNK_W-1:0]     state_chunk,
  output logic [kf200_pkg::CHUNK_IDX_W-1:0] chunk_index,
  output logic                              last_chunk
);
  import kf200_pkg::*;

  lanes_t                 held;
  logic [CHUNK_IDX_W-1:0] idx;
  logic                   valid;
  logic                   take;
  logic [4:0]             lane_sel [CHUNK_LANES];

  assign take        = valid && out_ready;
  assign out_valid   = valid;
  assign chunk_index = idx;
  assign last_chunk  = (idx == LAST_CHUNK_IDX);
  assign out_free    = !valid || (take && last_chunk);

  // select the eight lanes of the current chunk, lanes past the state read zero
  always_comb begin
    state_chunk = '0;
    for (int i = 0; i < CHUNK_LANES; i++) begin
      lane_sel[i] = {idx, 3'(i)};
      if (lane_sel[i] < 5'(LANE_COUNT)) begin
        state_chunk[8*i +: 8] = held[lane_sel[i]];
      end
    end
  end

  // snapshot storage
  always_ff @(posedge clk) begin
    if (snap.load) begin
      held <= snap.lanes;
    end
  end

  // chunk sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (snap.load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (take) begin
      if (last_chunk) begin
        valid <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + CHUNK_IDX_W'(1);
      end
    end
  end

endmodule

[rtl/keccak_f200_sponge_absorb.sv]
// ----------------------------------------------------------------------------
// keccak_f200_sponge_absorb
// Sponge absorber over Keccak-f[200] with a 72-bit rate and chunked readout.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready): one rate block per transfer, nine
// 8-bit lanes lane_0..lane_8 (lane index x+5y) and final_block. The block is
// XORed into the rate lanes and the last ROUNDS rounds of Keccak-f[200] run.
// Output channel (out_valid / out_ready): after a final block the 200-bit
// state leaves as four transfers of state_chunk, chunk_index 0..3, with
// last_chunk on the fourth; chunk 3 holds lane 24 in its low byte only.
// The permutation unit evaluates three rounds per clock, unless a final
// block is stalled at its last step, with the state fed back into itself,
// and takes the next block only after the last step of the current one.
// A final state is registered in the chunk serializer before its first chunk.
// A two-entry block queue takes new blocks while the rounds run, and the
// chunk serializer holds its own copy of the state, so absorbing goes on
// while chunks drain. If the receiver stalls, a second final block waits
// at its last step until the previous four chunks are gone.
// Reset (rst, synchronous) clears the state to zero and empties the queue
// and the serializer. A final block does not clear the state.
// ----------------------------------------------------------------------------
module keccak_f200_sponge_absorb #(
  parameter int ROUNDS     = kf200_pkg::DEF_ROUNDS,
  parameter int RATE_LANES = kf200_pkg::DEF_RATE_LANES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        lane_0,
  input  logic [7:0]                        lane_1,
  input  logic [7:0]                        lane_2,
  input  logic [7:0]                        lane_3,
  input  logic [7:0]                        lane_4,
  input  logic [7:0]                        lane_5,
  input  logic [7:0]                        lane_6,
  input  logic [7:0]                        lane_7,
  input  logic [7:0]                        lane_8,
  input  logic                              final_block,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kf200_pkg::CHUNK_W-1:0]     state_chunk,
  output logic [kf200_pkg::CHUNK_IDX_W-1:0] chunk_index,
  output logic                              last_chunk
);
  import kf200_pkg::*;

  blk_t  in_item;
  blk_t  q_item;
  logic  q_valid;
  logic  q_pop;
  logic  out_free;
  snap_t snap;

  // gather the input block
  assign in_item.lanes = {lane_8, lane_7, lane_6, lane_5, lane_4,
                          lane_3, lane_2, lane_1, lane_0};
  assign in_item.final_block = final_block;

  // block queue
  kf200_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // absorb and permute
  kf200_perm #(
    .ROUNDS     (ROUNDS),
    .RATE_LANES (RATE_LANES)
  ) u_perm (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .snap     (snap)
  );

  // chunk readout
  kf200_out u_out (
    .clk         (clk),
    .rst         (rst),
    .snap        (snap),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .state_chunk (state_chunk),
    .chunk_index (chunk_index),
    .last_chunk  (last_chunk)
  );

endmodule

[rtl/kf200_check.sv]
// ----------------------------------------------------------------------------
// kf200_check
// Port-level checks for the sponge absorber: reset behavior, chunk order,
// last-chunk marking and a held result under stall.
// ----------------------------------------------------------------------------
module kf200_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [kf200_pkg::CHUNK_W-1:0]     state_chunk,
  input logic [kf200_pkg::CHUNK_IDX_W-1:0] chunk_index,
  input logic                              last_chunk
);
  import kf200_pkg::*;

  // reset empties the serializer and opens the queue
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("not idle after reset");

  // a stalled chunk holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(state_chunk) && $stable(chunk_index)))
    else $error("chunk changed under stall");

  // chunks of one state leave in ascending order without gaps
  a_chunk_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_chunk) |=>
      (out_valid && chunk_index == $past(chunk_index) + CHUNK_IDX_W'(1)))
    else $error("chunk sequence broken");

  // the last chunk is index three and carries only lane 24
  a_last_chunk: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((last_chunk == (chunk_index == LAST_CHUNK_IDX)) &&
                   (!last_chunk || state_chunk[CHUNK_W-1:8] == '0)))
    else $error("last chunk marking wrong");

endmodule

bind keccak_f200_sponge_absorb kf200_check u_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .state_chunk (state_chunk),
  .chunk_index (chunk_index),
  .last_chunk  (last_chunk)
);

[tb/sv/kf200_absorb_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kf200_absorb_checker
// Watches both channels of the Keccak-f[200] sponge absorber. It keeps its own
// 25-lane state, absorbs every block transfer into it and runs the rounds.
// After each final block it queues the four expected readout chunks, then
// compares every readout transfer field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module kf200_absorb_checker #(
  parameter int ROUNDS     = 18,
  parameter int RATE_LANES = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [7:0]                        lane_0,
  input  logic [7:0]                        lane_1,
  input  logic [7:0]                        lane_2,
  input  logic [7:0]                        lane_3,
  input  logic [7:0]                        lane_4,
  input  logic [7:0]                        lane_5,
  input  logic [7:0]                        lane_6,
  input  logic [7:0]                        lane_7,
  input  logic [7:0]                        lane_8,
  input  logic                              final_block,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [kf200_pkg::CHUNK_W-1:0]     state_chunk,
  input  logic [kf200_pkg::CHUNK_IDX_W-1:0] chunk_index,
  input  logic                              last_chunk,
  output int                                fail_count,
  output int                                chunks_pending
);

  localparam int NUM_LANES        = 25;
  localparam int BLOCK_LANES      = 9;
  localparam int FULL_ROUNDS      = 18;
  localparam int CHUNKS_PER_STATE = 4;
  localparam int LANES_PER_CHUNK  = 8;

  typedef logic [NUM_LANES-1:0][7:0] sponge_t;

  typedef struct packed {
    logic [kf200_pkg::CHUNK_W-1:0]     data;
    logic [kf200_pkg::CHUNK_IDX_W-1:0] index;
    logic                              last;
  } readout_t;

  // rotation offsets mod 8, by lane x+5y
  localparam logic [2:0] RHO_OFFS [NUM_LANES] = '{
    3'd0, 3'd1, 3'd6, 3'd4, 3'd3,
    3'd4, 3'd4, 3'd6, 3'd7, 3'd4,
    3'd3, 3'd2, 3'd3, 3'd1, 3'd7,
    3'd1, 3'd5, 3'd7, 3'd5, 3'd0,
    3'd2, 3'd2, 3'd5, 3'd0, 3'd6
  };

  // low bytes of the standard round constants
  localparam logic [7:0] IOTA_RC [FULL_ROUNDS] = '{
    8'h01, 8'h82, 8'h8A, 8'h00, 8'h8B, 8'h01, 8'h81, 8'h09, 8'h8A,
    8'h88, 8'h09, 8'h0A, 8'h8B, 8'h8B, 8'h89, 8'h03, 8'h02, 8'h80
  };

  sponge_t  absorb_state = '0;
  readout_t pending_chunks[$];
  int       mismatch_count = 0;

  function automatic logic [7:0] rot_left8(logic [7:0] v, logic [2:0] r);
    return (v << r) | (v >> (4'd8 - r));
  endfunction

  // theta, rho, pi, chi and iota on the whole state
  function automatic sponge_t keccak_round_step(sponge_t a, logic [7:0] rc);
    logic [4:0][7:0] par;
    logic [4:0][7:0] mix;
    sponge_t         b;
    sponge_t         res;
    for (int x = 0; x < 5; x++) begin
      par[x] = a[x] ^ a[x + 5] ^ a[x + 10] ^ a[x + 15] ^ a[x + 20];
    end
    for (int x = 0; x < 5; x++) begin
      mix[x] = par[(x + 4) % 5] ^ rot_left8(par[(x + 1) % 5], 3'd1);
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      a[i] = a[i] ^ mix[i % 5];
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[y + 5 * ((2 * x + 3 * y) % 5)] = rot_left8(a[x + 5 * y], RHO_OFFS[x + 5 * y]);
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        res[x + 5 * y] = b[x + 5 * y] ^
                         (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
      end
    end
    res[0] = res[0] ^ rc;
    return res;
  endfunction

  // only the last ROUNDS of the full round schedule run
  function automatic sponge_t permute_sponge(sponge_t s);
    for (int r = 0; r < FULL_ROUNDS; r++) begin
      if (r + ROUNDS >= FULL_ROUNDS) begin
        s = keccak_round_step(s, IOTA_RC[r]);
      end
    end
    return s;
  endfunction

  always @(posedge clk) begin
    readout_t                    oldest;
    readout_t                    chunk;
    logic [BLOCK_LANES-1:0][7:0] blk;
    if (rst) begin
      absorb_state = '0;
      pending_chunks.delete();
    end else begin
      // readout transfer against the oldest expected chunk
      if (out_valid && out_ready) begin
        if (pending_chunks.size() == 0) begin
          $error("unexpected chunk transfer: state_chunk %h chunk_index %0d last_chunk %0b",
                 state_chunk, chunk_index, last_chunk);
          mismatch_count++;
        end else begin
          oldest = pending_chunks.pop_front();
          if (state_chunk !== oldest.data) begin
            $error("state_chunk mismatch: expected %h actual %h", oldest.data, state_chunk);
            mismatch_count++;
          end
          if (chunk_index !== oldest.index) begin
            $error("chunk_index mismatch: expected %0d actual %0d", oldest.index,
                   chunk_index);
            mismatch_count++;
          end
          if (last_chunk !== oldest.last) begin
            $error("last_chunk mismatch: expected %0b actual %0b", oldest.last, last_chunk);
            mismatch_count++;
          end
        end
      end
      // block transfer: absorb the rate lanes and permute
      if (in_valid && in_ready) begin
        blk = {lane_8, lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};
        for (int i = 0; i < BLOCK_LANES; i++) begin
          if (i < RATE_LANES) begin
            absorb_state[i] = absorb_state[i] ^ blk[i];
          end
        end
        absorb_state = permute_sponge(absorb_state);
        // final block: the whole state leaves as four chunks
        if (final_block) begin
          for (int k = 0; k < CHUNKS_PER_STATE; k++) begin
            chunk.data = '0;
            for (int i = 0; i < LANES_PER_CHUNK; i++) begin
              if (k * LANES_PER_CHUNK + i < NUM_LANES) begin
                chunk.data[8 * i +: 8] = absorb_state[k * LANES_PER_CHUNK + i];
              end
            end
            chunk.index = kf200_pkg::CHUNK_IDX_W'(k);
            chunk.last  = (chunk.index == kf200_pkg::LAST_CHUNK_IDX);
            pending_chunks.push_back(chunk);
          end
        end
      end
    end
    fail_count     <= mismatch_count;
    chunks_pending <= pending_chunks.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives rate blocks into the sponge absorber and pulls its readout chunks,
// with random sender gaps and receiver stalls in several phases. A directed
// set comes first, then random blocks; the checker beside the block predicts
// and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ROUNDS        = 18;
  localparam int RATE_LANES    = 9;
  localparam int BLOCK_LANES   = 9;
  localparam int PHASE_COUNT   = 4;
  localparam int PHASE_BLOCKS  = 95;
  localparam int FINAL_PCT     = 30;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RESET_CYCLES  = 6;

  typedef logic [BLOCK_LANES-1:0][7:0] rate_block_t;

  logic                              clk         = 1'b0;
  logic                              rst         = 1'b1;
  logic                              in_valid    = 1'b0;
  logic                              in_ready;
  logic [7:0]                        lane_0      = '0;
  logic [7:0]                        lane_1      = '0;
  logic [7:0]                        lane_2      = '0;
  logic [7:0]                        lane_3      = '0;
  logic [7:0]                        lane_4      = '0;
  logic [7:0]                        lane_5      = '0;
  logic [7:0]                        lane_6      = '0;
  logic [7:0]                        lane_7      = '0;
  logic [7:0]                        lane_8      = '0;
  logic                              final_block = 1'b0;
  logic                              out_valid;
  logic                              out_ready   = 1'b0;
  logic [kf200_pkg::CHUNK_W-1:0]     state_chunk;
  logic [kf200_pkg::CHUNK_IDX_W-1:0] chunk_index;
  logic                              last_chunk;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count;
  int chunks_pending;

  keccak_f200_sponge_absorb #(
    .ROUNDS     (ROUNDS),
    .RATE_LANES (RATE_LANES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .lane_0      (lane_0),
    .lane_1      (lane_1),
    .lane_2      (lane_2),
    .lane_3      (lane_3),
    .lane_4      (lane_4),
    .lane_5      (lane_5),
    .lane_6      (lane_6),
    .lane_7      (lane_7),
    .lane_8      (lane_8),
    .final_block (final_block),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .state_chunk (state_chunk),
    .chunk_index (chunk_index),
    .last_chunk  (last_chunk)
  );

  kf200_absorb_checker #(
    .ROUNDS     (ROUNDS),
    .RATE_LANES (RATE_LANES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .lane_0         (lane_0),
    .lane_1         (lane_1),
    .lane_2         (lane_2),
    .lane_3         (lane_3),
    .lane_4         (lane_4),
    .lane_5         (lane_5),
    .lane_6         (lane_6),
    .lane_7         (lane_7),
    .lane_8         (lane_8),
    .final_block    (final_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .state_chunk    (state_chunk),
    .chunk_index    (chunk_index),
    .last_chunk     (last_chunk),
    .fail_count     (fail_count),
    .chunks_pending (chunks_pending)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one block transfer, after a random gap
  task automatic send_block(input rate_block_t blk, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    lane_0      <= blk[0];
    lane_1      <= blk[1];
    lane_2      <= blk[2];
    lane_3      <= blk[3];
    lane_4      <= blk[4];
    lane_5      <= blk[5];
    lane_6      <= blk[6];
    lane_7      <= blk[7];
    lane_8      <= blk[8];
    final_block <= fin;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // lanes mostly random, with the all-zero and all-one bytes mixed in
  function automatic rate_block_t rand_block();
    rate_block_t blk;
    int          pick;
    for (int i = 0; i < BLOCK_LANES; i++) begin
      pick = $urandom_range(7);
      if (pick == 0) begin
        blk[i] = 8'h00;
      end else if (pick == 1) begin
        blk[i] = 8'hFF;
      end else begin
        blk[i] = 8'($urandom);
      end
    end
    return blk;
  endfunction

  // run limit
  initial begin
    #4_000_000;
    $display("[keccak_f200_sponge_absorb] ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rate_block_t walk;
    int          idle_tab  [PHASE_COUNT];
    int          stall_tab [PHASE_COUNT];
    idle_tab  = '{0, 67, 0, 26};
    stall_tab = '{0, 0, 67, 26};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // permutation of the zero state, then all-one and alternating lanes
    send_block('0, 1'b1);
    send_block({BLOCK_LANES{8'hFF}}, 1'b1);
    send_block({BLOCK_LANES{8'hAA}}, 1'b0);
    send_block({BLOCK_LANES{8'h55}}, 1'b1);
    // walking one across the lanes, several blocks absorbed before readout
    for (int i = 0; i < BLOCK_LANES; i++) begin
      walk    = '0;
      walk[i] = 8'h01 << (i % 8);
      send_block(walk, (i == BLOCK_LANES - 1));
    end
    // state kept after a final block: keep absorbing zeros
    send_block('0, 1'b0);
    send_block('0, 1'b1);
    // back-to-back final blocks against a mostly stalled receiver
    recv_stall_pct <= 90;
    send_block({BLOCK_LANES{8'hFF}}, 1'b1);
    send_block(rand_block(), 1'b1);
    send_block('0, 1'b1);
    recv_stall_pct <= 0;

    // random blocks under each idling pattern
    for (int p = 0; p < PHASE_COUNT; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct <= stall_tab[p];
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        send_block(rand_block(), ($urandom_range(99) < FINAL_PCT));
      end
    end
    in_valid <= 1'b0;

    // drain the readout, then watch for stray chunks
    while (chunks_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[keccak_f200_sponge_absorb] OK");
    end else begin
      $display("[keccak_f200_sponge_absorb] ERROR");
    end
    $finish;
  end

endmodule
